// ===== rtl/core/ptc_pkg.sv =====
package ptc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REST_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_THR = 1'd1;

  localparam logic [BYTE_W-1:0] REST_CODE_RST = 8'd127;
  localparam logic [BYTE_W-1:0] ALARM_THR_RST = 8'd20;
  localparam logic [BYTE_W-1:0] BAD_COUNT_MAX = 8'd255;
  localparam logic [BYTE_W-1:0] SPEED_STEP    = 8'd10;

  localparam int unsigned MODE_AZ_TRACK = 0;
  localparam int unsigned MODE_EL_TRACK = 1;
  localparam int unsigned MODE_AZ_PLUS  = 2;
  localparam int unsigned MODE_AZ_MINUS = 3;
  localparam int unsigned MODE_EL_PLUS  = 4;
  localparam int unsigned MODE_EL_MINUS = 5;
  localparam int unsigned MODE_ROT_PLUS = 6;
  localparam int unsigned MODE_ROT_MINUS = 7;

  localparam int unsigned SPH_AZ_TRACK_EN = 5;
  localparam int unsigned SPH_EL_TRACK_EN = 6;

  typedef struct packed {
    logic fresh;
    logic crc_alarm;
    logic check_fault;
    logic count_fault;
  } frm_status_t;

endpackage

// ===== rtl/core/ptc_frame_check.sv =====
module ptc_frame_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      update,
  input  logic [ptc_pkg::BYTE_W-1:0] alarm_thr,
  input  logic [ptc_pkg::BYTE_W-1:0] sequence_req,
  input  logic [ptc_pkg::BYTE_W-1:0] mode_bits,
  input  logic [ptc_pkg::POS_W-1:0]  az_target,
  input  logic [ptc_pkg::POS_W-1:0]  el_target,
  input  logic [ptc_pkg::BYTE_W-1:0] speed_low,
  input  logic [ptc_pkg::BYTE_W-1:0] speed_high,
  input  logic [ptc_pkg::BYTE_W-1:0] frame_check,
  output ptc_pkg::frm_status_t       status
);
  import ptc_pkg::*;

  logic [BYTE_W-1:0] last_seq_r, last_seq_nxt;
  logic [BYTE_W-1:0] bad_cnt_r, bad_cnt_nxt;
  logic              crc_alarm_r, crc_alarm_nxt;
  logic              check_flag_r, check_flag_nxt;
  logic              count_flag_r, count_flag_nxt;
  logic              fresh;
  logic              good;
  logic              over;
  logic [BYTE_W-1:0] sum;

  always_comb begin
    fresh = sequence_req != last_seq_r;
    sum = (sequence_req - 8'd1) ^ mode_bits ^ az_target[7:0] ^ az_target[15:8]
        ^ el_target[7:0] ^ el_target[15:8] ^ speed_low ^ speed_high;
    good = sum == frame_check;
    last_seq_nxt   = last_seq_r;
    bad_cnt_nxt    = bad_cnt_r;
    crc_alarm_nxt  = crc_alarm_r;
    check_flag_nxt = check_flag_r;
    count_flag_nxt = count_flag_r;
    over = 1'b0;
    if (fresh) begin
      last_seq_nxt = sequence_req;
      if (good) begin
        bad_cnt_nxt    = '0;
        check_flag_nxt = 1'b0;
        count_flag_nxt = 1'b0;
      end else begin
        check_flag_nxt = 1'b1;
        if (bad_cnt_r != BAD_COUNT_MAX) begin
          bad_cnt_nxt = bad_cnt_r + 8'd1;
        end
      end
      over = bad_cnt_nxt > alarm_thr;
      crc_alarm_nxt = over;
      if (over) begin
        count_flag_nxt = 1'b1;
      end
    end
    status.fresh       = fresh;
    status.crc_alarm   = crc_alarm_nxt;
    status.check_fault = check_flag_nxt;
    status.count_fault = count_flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r   <= '0;
      bad_cnt_r    <= '0;
      crc_alarm_r  <= 1'b0;
      check_flag_r <= 1'b0;
      count_flag_r <= 1'b0;
    end else if (update) begin
      last_seq_r   <= last_seq_nxt;
      bad_cnt_r    <= bad_cnt_nxt;
      crc_alarm_r  <= crc_alarm_nxt;
      check_flag_r <= check_flag_nxt;
      count_flag_r <= count_flag_nxt;
    end
  end

endmodule

// ===== rtl/core/ptc_axis_speed.sv =====
module ptc_axis_speed (
  input  logic                       track_mode,
  input  logic                       track_en,
  input  logic                       fault,
  input  logic [ptc_pkg::POS_W-1:0]  target,
  input  logic [ptc_pkg::POS_W-1:0]  position,
  input  logic                       plus,
  input  logic                       minus,
  input  logic [ptc_pkg::NIB_W-1:0]  nib,
  input  logic [ptc_pkg::BYTE_W-1:0] rest_code,
  output logic [ptc_pkg::BYTE_W-1:0] speed
);
  import ptc_pkg::*;

  logic [BYTE_W-1:0]       lim;
  logic [POS_W-1:0]        diff;
  logic signed [POS_W:0]   err;
  logic signed [POS_W:0]   lim_s;
  logic [BYTE_W-1:0]       err_lo;

  always_comb begin
    lim   = SPEED_STEP * {{(BYTE_W-NIB_W){1'b0}}, nib};
    diff  = target - position;
    err   = $signed({diff[POS_W-1], diff});
    lim_s = $signed({{(POS_W+1-BYTE_W){1'b0}}, lim});
    if (err > lim_s) begin
      err_lo = lim;
    end else if (err < -lim_s) begin
      err_lo = -lim;
    end else begin
      err_lo = err[BYTE_W-1:0];
    end
    if (track_mode) begin
      if (!track_en || fault) begin
        speed = rest_code;
      end else begin
        speed = rest_code + err_lo;
      end
    end else if (plus) begin
      speed = rest_code + lim;
    end else if (minus) begin
      speed = rest_code - lim;
    end else begin
      speed = rest_code;
    end
  end

endmodule

// ===== rtl/core/pan_tilt_command_frame_handler.sv =====
// Channel | Ports                                   | Direction
// in      | in_valid, in_stall, in_<field>          | request in, stall out
// out     | out_valid, out_stall, out_<field>       | result out, stall in
// cfg     | cfg_we, cfg_index, cfg_wdata            | write only
//
// One request per cycle while out_stall is low; a moving request sets out_valid.
// The input register feeds the checksum/state update and the three axis units,
// which load the result register; frame state updates as a request moves on.
// Synchronous active-low reset clears state, valids and config to defaults.
// A stalled result holds; in_stall rises only while both registers hold requests
// and the result is stalled.
module pan_tilt_command_frame_handler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptc_pkg::BYTE_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ptc_pkg::BYTE_W-1:0] in_sequence_req,
  input  logic [ptc_pkg::BYTE_W-1:0] in_mode_bits,
  input  logic [ptc_pkg::POS_W-1:0]  in_az_target,
  input  logic [ptc_pkg::POS_W-1:0]  in_el_target,
  input  logic [ptc_pkg::BYTE_W-1:0] in_speed_low,
  input  logic [ptc_pkg::BYTE_W-1:0] in_speed_high,
  input  logic [ptc_pkg::BYTE_W-1:0] in_frame_check,
  input  logic [ptc_pkg::POS_W-1:0]  in_az_position,
  input  logic [ptc_pkg::POS_W-1:0]  in_el_position,
  input  logic                       in_az_sensor_fault,
  input  logic                       in_el_sensor_fault,
  input  logic                       in_timeout_stop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ptc_pkg::BYTE_W-1:0] out_az_speed,
  output logic [ptc_pkg::BYTE_W-1:0] out_el_speed,
  output logic [ptc_pkg::BYTE_W-1:0] out_rot_speed,
  output logic                       out_new_frame,
  output logic                       out_check_fault,
  output logic                       out_count_fault,
  output logic                       out_stopped
);
  import ptc_pkg::*;

  logic [BYTE_W-1:0] rest_code_r;
  logic [BYTE_W-1:0] alarm_thr_r;

  logic              in_vld_r;
  logic [BYTE_W-1:0] seq_r, mode_r, spl_r, sph_r, chk_r;
  logic [POS_W-1:0]  azt_r, elt_r, azp_r, elp_r;
  logic              azf_r, elf_r, tstop_r;

  logic              out_vld_r;
  logic [BYTE_W-1:0] az_r, el_r, rot_r;
  logic              new_r, chkf_r, cntf_r, stop_r;

  logic              advance;
  logic              move;
  logic              take;
  logic              stop;
  frm_status_t       status;
  logic [BYTE_W-1:0] az_spd, el_spd, rot_spd;

  assign advance  = !out_vld_r || !out_stall;
  assign move     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_code_r <= REST_CODE_RST;
      alarm_thr_r <= ALARM_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REST_CODE: rest_code_r <= cfg_wdata;
        CFG_ALARM_THR: alarm_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (take) begin
      in_vld_r <= 1'b1;
    end else if (move) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seq_r   <= in_sequence_req;
      mode_r  <= in_mode_bits;
      azt_r   <= in_az_target;
      elt_r   <= in_el_target;
      spl_r   <= in_speed_low;
      sph_r   <= in_speed_high;
      chk_r   <= in_frame_check;
      azp_r   <= in_az_position;
      elp_r   <= in_el_position;
      azf_r   <= in_az_sensor_fault;
      elf_r   <= in_el_sensor_fault;
      tstop_r <= in_timeout_stop;
    end
  end

  ptc_frame_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .update       (move),
    .alarm_thr    (alarm_thr_r),
    .sequence_req (seq_r),
    .mode_bits    (mode_r),
    .az_target    (azt_r),
    .el_target    (elt_r),
    .speed_low    (spl_r),
    .speed_high   (sph_r),
    .frame_check  (chk_r),
    .status       (status)
  );

  ptc_axis_speed u_az (
    .track_mode (mode_r[MODE_AZ_TRACK]),
    .track_en   (sph_r[SPH_AZ_TRACK_EN]),
    .fault      (azf_r),
    .target     (azt_r),
    .position   (azp_r),
    .plus       (mode_r[MODE_AZ_PLUS]),
    .minus      (mode_r[MODE_AZ_MINUS]),
    .nib        (spl_r[NIB_W-1:0]),
    .rest_code  (rest_code_r),
    .speed      (az_spd)
  );

  ptc_axis_speed u_el (
    .track_mode (mode_r[MODE_EL_TRACK]),
    .track_en   (sph_r[SPH_EL_TRACK_EN]),
    .fault      (elf_r),
    .target     (elt_r),
    .position   (elp_r),
    .plus       (mode_r[MODE_EL_PLUS]),
    .minus      (mode_r[MODE_EL_MINUS]),
    .nib        (spl_r[BYTE_W-1:NIB_W]),
    .rest_code  (rest_code_r),
    .speed      (el_spd)
  );

  ptc_axis_speed u_rot (
    .track_mode (1'b0),
    .track_en   (1'b0),
    .fault      (1'b0),
    .target     ('0),
    .position   ('0),
    .plus       (mode_r[MODE_ROT_PLUS]),
    .minus      (mode_r[MODE_ROT_MINUS]),
    .nib        (sph_r[NIB_W-1:0]),
    .rest_code  (rest_code_r),
    .speed      (rot_spd)
  );

  assign stop = status.crc_alarm || tstop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      az_r   <= stop ? rest_code_r : az_spd;
      el_r   <= stop ? rest_code_r : el_spd;
      rot_r  <= stop ? rest_code_r : rot_spd;
      new_r  <= status.fresh;
      chkf_r <= status.check_fault;
      cntf_r <= status.count_fault;
      stop_r <= stop;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_az_speed    = az_r;
  assign out_el_speed    = el_r;
  assign out_rot_speed   = rot_r;
  assign out_new_frame   = new_r;
  assign out_check_fault = chkf_r;
  assign out_count_fault = cntf_r;
  assign out_stopped     = stop_r;

  a_count_needs_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count_fault |-> out_check_fault)
    else $error("count fault without check fault");

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stopped |-> out_az_speed == rest_code_r
      && out_el_speed == rest_code_r && out_rot_speed == rest_code_r)
    else $error("stopped result with nonzero speed");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> !in_stall)
    else $error("input stalled while result register empty");

  a_move_fills: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> out_vld_r)
    else $error("request moved but no result");

endmodule

// ===== verif/ptc_frame_check_pkg.sv =====
package ptc_frame_check_pkg;
  import ptc_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] seq;
    logic [BYTE_W-1:0] mode;
    logic [POS_W-1:0]  az_target;
    logic [POS_W-1:0]  el_target;
    logic [BYTE_W-1:0] speed_low;
    logic [BYTE_W-1:0] speed_high;
    logic [BYTE_W-1:0] frame_check;
    logic [POS_W-1:0]  az_position;
    logic [POS_W-1:0]  el_position;
    logic              az_fault;
    logic              el_fault;
    logic              timeout_stop;
  } frame_t;

  typedef struct packed {
    logic [BYTE_W-1:0] az_speed;
    logic [BYTE_W-1:0] el_speed;
    logic [BYTE_W-1:0] rot_speed;
    logic              new_frame;
    logic              check_fault;
    logic              count_fault;
    logic              stopped;
  } drive_t;

  function automatic logic [BYTE_W-1:0] frame_sum(frame_t f);
    return (f.seq - 8'd1) ^ f.mode ^ f.az_target[7:0] ^ f.az_target[15:8]
           ^ f.el_target[7:0] ^ f.el_target[15:8] ^ f.speed_low ^ f.speed_high;
  endfunction

  class frame_tracker;
    logic [BYTE_W-1:0] rest_code;
    logic [BYTE_W-1:0] alarm_thr;
    logic [BYTE_W-1:0] last_seq;
    logic [BYTE_W-1:0] bad_count;
    bit                crc_alarm;
    bit                check_flag;
    bit                count_flag;
    drive_t            expected_q[$];
    int unsigned       errors;
    int unsigned       requests;
    int unsigned       fresh_frames;
    int unsigned       bad_frames;
    int unsigned       alarm_results;
    int unsigned       stop_results;

    function new();
      rest_code     = REST_CODE_RST;
      alarm_thr     = ALARM_THR_RST;
      last_seq      = '0;
      bad_count     = '0;
      crc_alarm     = 1'b0;
      check_flag    = 1'b0;
      count_flag    = 1'b0;
      errors        = 0;
      requests      = 0;
      fresh_frames  = 0;
      bad_frames    = 0;
      alarm_results = 0;
      stop_results  = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
      if (idx == CFG_REST_CODE) begin
        rest_code = val;
      end else if (idx == CFG_ALARM_THR) begin
        alarm_thr = val;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function logic [BYTE_W-1:0] manual_drive(bit plus, bit minus, logic [NIB_W-1:0] nib);
      logic [BYTE_W-1:0] step;
      step = nib * SPEED_STEP;
      if (plus) return rest_code + step;
      if (minus) return rest_code - step;
      return rest_code;
    endfunction

    function logic [BYTE_W-1:0] track_drive(bit enable, bit fault, logic [POS_W-1:0] target,
                                            logic [POS_W-1:0] position,
                                            logic [NIB_W-1:0] nib);
      logic [POS_W-1:0] diff;
      int               err;
      int               lim;
      if (!enable || fault) return rest_code;
      diff = target - position;
      err  = $signed(diff);
      lim  = int'(nib) * 10;
      if (err > lim) err = lim;
      if (err < -lim) err = -lim;
      return rest_code + 8'(err);
    endfunction

    function void note_request(frame_t f);
      drive_t d;
      bit     fresh;
      bit     stop;
      fresh = (f.seq != last_seq);
      requests++;
      if (fresh) begin
        fresh_frames++;
        last_seq  = f.seq;
        crc_alarm = 1'b0;
        if (frame_sum(f) == f.frame_check) begin
          check_flag = 1'b0;
          count_flag = 1'b0;
          bad_count  = '0;
        end else begin
          bad_frames++;
          check_flag = 1'b1;
          if (bad_count != BAD_COUNT_MAX) bad_count++;
        end
        if (bad_count > alarm_thr) begin
          crc_alarm  = 1'b1;
          count_flag = 1'b1;
        end
      end
      stop = crc_alarm || f.timeout_stop;
      if (stop) begin
        d.az_speed  = rest_code;
        d.el_speed  = rest_code;
        d.rot_speed = rest_code;
      end else begin
        d.az_speed = f.mode[MODE_AZ_TRACK]
          ? track_drive(f.speed_high[SPH_AZ_TRACK_EN], f.az_fault, f.az_target,
                        f.az_position, f.speed_low[3:0])
          : manual_drive(f.mode[MODE_AZ_PLUS], f.mode[MODE_AZ_MINUS], f.speed_low[3:0]);
        d.el_speed = f.mode[MODE_EL_TRACK]
          ? track_drive(f.speed_high[SPH_EL_TRACK_EN], f.el_fault, f.el_target,
                        f.el_position, f.speed_low[7:4])
          : manual_drive(f.mode[MODE_EL_PLUS], f.mode[MODE_EL_MINUS], f.speed_low[7:4]);
        d.rot_speed = manual_drive(f.mode[MODE_ROT_PLUS], f.mode[MODE_ROT_MINUS],
                                   f.speed_high[3:0]);
      end
      d.new_frame   = fresh;
      d.check_fault = check_flag;
      d.count_fault = count_flag;
      d.stopped     = stop;
      if (count_flag) alarm_results++;
      if (stop) stop_results++;
      expected_q.push_back(d);
    endfunction

    function void compare_field(string name, logic [BYTE_W-1:0] want, logic [BYTE_W-1:0] got);
      if (want !== got) begin
        if (errors < 10) begin
          $display("mismatch on %s: expected %0h, got %0h", name, want, got);
        end
        errors++;
      end
    endfunction

    function void check_result(drive_t got);
      drive_t want;
      if (expected_q.size() == 0) begin
        if (errors < 10) begin
          $display("result with no request outstanding: %p", got);
        end
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("az_speed", want.az_speed, got.az_speed);
      compare_field("el_speed", want.el_speed, got.el_speed);
      compare_field("rot_speed", want.rot_speed, got.rot_speed);
      compare_field("new_frame", 8'(want.new_frame), 8'(got.new_frame));
      compare_field("check_fault", 8'(want.check_fault), 8'(got.check_fault));
      compare_field("count_fault", 8'(want.count_fault), 8'(got.count_fault));
      compare_field("stopped", 8'(want.stopped), 8'(got.stopped));
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
module tb_top;
  import ptc_pkg::*;
  import ptc_frame_check_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int PHASE_LEN [PHASES] = '{200, 340, 190, 190, 190, 190};
  localparam int PHASE_BAD [PHASES] = '{30, 100, 35, 40, 25, 20};
  localparam int PHASE_ZS  [PHASES] = '{0, 255, 127, 0, 10, 0};
  localparam int PHASE_THR [PHASES] = '{0, 255, 3, 0, 1, 20};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BYTE_W-1:0]     cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_sequence_req = '0;
  logic [BYTE_W-1:0]     in_mode_bits = '0;
  logic [POS_W-1:0]      in_az_target = '0;
  logic [POS_W-1:0]      in_el_target = '0;
  logic [BYTE_W-1:0]     in_speed_low = '0;
  logic [BYTE_W-1:0]     in_speed_high = '0;
  logic [BYTE_W-1:0]     in_frame_check = '0;
  logic [POS_W-1:0]      in_az_position = '0;
  logic [POS_W-1:0]      in_el_position = '0;
  logic                  in_az_sensor_fault = 1'b0;
  logic                  in_el_sensor_fault = 1'b0;
  logic                  in_timeout_stop = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [BYTE_W-1:0]     out_az_speed;
  logic [BYTE_W-1:0]     out_el_speed;
  logic [BYTE_W-1:0]     out_rot_speed;
  logic                  out_new_frame;
  logic                  out_check_fault;
  logic                  out_count_fault;
  logic                  out_stopped;

  int unsigned           send_pct = 0;
  int unsigned           recv_pct = 0;
  int unsigned           cycle_count = 0;
  logic [BYTE_W-1:0]     seq_cursor = '0;
  frame_tracker          tracker = new();

  pan_tilt_command_frame_handler dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sequence_req    (in_sequence_req),
    .in_mode_bits       (in_mode_bits),
    .in_az_target       (in_az_target),
    .in_el_target       (in_el_target),
    .in_speed_low       (in_speed_low),
    .in_speed_high      (in_speed_high),
    .in_frame_check     (in_frame_check),
    .in_az_position     (in_az_position),
    .in_el_position     (in_el_position),
    .in_az_sensor_fault (in_az_sensor_fault),
    .in_el_sensor_fault (in_el_sensor_fault),
    .in_timeout_stop    (in_timeout_stop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_az_speed       (out_az_speed),
    .out_el_speed       (out_el_speed),
    .out_rot_speed      (out_rot_speed),
    .out_new_frame      (out_new_frame),
    .out_check_fault    (out_check_fault),
    .out_count_fault    (out_count_fault),
    .out_stopped        (out_stopped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_pct);
  end

  always @(posedge clk) begin : result_monitor
    drive_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.az_speed    = out_az_speed;
      got.el_speed    = out_el_speed;
      got.rot_speed   = out_rot_speed;
      got.new_frame   = out_new_frame;
      got.check_fault = out_check_fault;
      got.count_fault = out_count_fault;
      got.stopped     = out_stopped;
      tracker.check_result(got);
    end
  end

  function automatic frame_t directed_frame(logic [7:0] seq, logic [7:0] mode,
                                            logic [15:0] azt, logic [15:0] elt,
                                            logic [7:0] spl, logic [7:0] sph,
                                            logic [15:0] azp, logic [15:0] elp,
                                            logic [2:0] faults, bit good);
    frame_t f;
    f.seq          = seq;
    f.mode         = mode;
    f.az_target    = azt;
    f.el_target    = elt;
    f.speed_low    = spl;
    f.speed_high   = sph;
    f.az_position  = azp;
    f.el_position  = elp;
    f.az_fault     = faults[2];
    f.el_fault     = faults[1];
    f.timeout_stop = faults[0];
    f.frame_check  = '0;
    f.frame_check  = frame_sum(f) ^ (good ? 8'h00 : 8'h5A);
    return f;
  endfunction

  function automatic logic [15:0] encoder_reading(logic [15:0] target);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return target + 16'($urandom_range(0, 400)) - 16'd200;
    if (pick < 66) return target ^ 16'h8000;
    return 16'($urandom);
  endfunction

  task automatic send_request(frame_t f);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_sequence_req    <= f.seq;
    in_mode_bits       <= f.mode;
    in_az_target       <= f.az_target;
    in_el_target       <= f.el_target;
    in_speed_low       <= f.speed_low;
    in_speed_high      <= f.speed_high;
    in_frame_check     <= f.frame_check;
    in_az_position     <= f.az_position;
    in_el_position     <= f.el_position;
    in_az_sensor_fault <= f.az_fault;
    in_el_sensor_fault <= f.el_fault;
    in_timeout_stop    <= f.timeout_stop;
    do @(posedge clk); while (in_stall);
    tracker.note_request(f);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [BYTE_W-1:0] zs, logic [BYTE_W-1:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REST_CODE;
    cfg_wdata <= zs;
    @(posedge clk);
    tracker.set_register(CFG_REST_CODE, zs);
    cfg_index <= CFG_ALARM_THR;
    cfg_wdata <= thr;
    @(posedge clk);
    tracker.set_register(CFG_ALARM_THR, thr);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random(int unsigned count, int unsigned bad_pct);
    frame_t      f;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      f.seq = (pick < 12) ? seq_cursor : (pick < 88) ? seq_cursor + 8'd1 : 8'($urandom);
      f.mode = 8'($urandom);
      f.az_target = 16'($urandom);
      f.el_target = 16'($urandom);
      f.az_position = encoder_reading(f.az_target);
      f.el_position = encoder_reading(f.el_target);
      f.speed_low = 8'($urandom);
      f.speed_high = 8'($urandom);
      if ($urandom_range(0, 3) != 0) f.speed_high[6:5] = 2'b11;
      f.az_fault = ($urandom_range(0, 9) == 0);
      f.el_fault = ($urandom_range(0, 9) == 0);
      f.timeout_stop = ($urandom_range(0, 11) == 0);
      f.frame_check = frame_sum(f);
      if ($urandom_range(0, 99) < bad_pct) begin
        f.frame_check = f.frame_check ^ 8'($urandom_range(1, 255));
      end
      seq_cursor = f.seq;
      send_request(f);
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin : stimulus
    logic [BYTE_W-1:0] zs;
    logic [BYTE_W-1:0] thr;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    recv_pct = 30;
    send_request(directed_frame(8'd0, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00,
                                16'h0000, 16'h0000, 3'b000, 1'b0));
    send_request(directed_frame(8'd1, 8'h54, 16'h0000, 16'h0000, 8'hFF, 8'h0F,
                                16'h0000, 16'h0000, 3'b000, 1'b1));
    send_request(directed_frame(8'd2, 8'hA8, 16'h0000, 16'h0000, 8'hFF, 8'h0F,
                                16'h0000, 16'h0000, 3'b000, 1'b1));
    send_request(directed_frame(8'd3, 8'hFC, 16'h1111, 16'h2222, 8'h9C, 8'h07,
                                16'h0000, 16'h0000, 3'b000, 1'b1));
    send_request(directed_frame(8'd4, 8'hFF, 16'h7FFF, 16'h0000, 8'hFF, 8'h60,
                                16'h0000, 16'h7FFF, 3'b000, 1'b1));
    send_request(directed_frame(8'd5, 8'h03, 16'h0000, 16'h8000, 8'h5A, 8'h60,
                                16'h8000, 16'h0000, 3'b000, 1'b1));
    send_request(directed_frame(8'd6, 8'h03, 16'd100, 16'd50, 8'hFF, 8'h7F,
                                16'd93, 16'd57, 3'b000, 1'b1));
    send_request(directed_frame(8'd7, 8'h03, 16'hFFFF, 16'h1234, 8'h33, 8'h60,
                                16'hFFFF, 16'h1234, 3'b000, 1'b1));
    send_request(directed_frame(8'd8, 8'h03, 16'h4000, 16'hC000, 8'hFF, 8'h0F,
                                16'h0000, 16'h0000, 3'b000, 1'b1));
    send_request(directed_frame(8'd9, 8'h03, 16'h4000, 16'hC000, 8'hFF, 8'h60,
                                16'h0000, 16'h0000, 3'b110, 1'b1));
    send_request(directed_frame(8'd10, 8'h57, 16'h0000, 16'h0000, 8'hFF, 8'h6F,
                                16'h0000, 16'h0000, 3'b001, 1'b1));
    send_request(directed_frame(8'd11, 8'h44, 16'h0000, 16'h0000, 8'h11, 8'h01,
                                16'h0000, 16'h0000, 3'b000, 1'b0));
    send_request(directed_frame(8'd11, 8'h44, 16'h0000, 16'h0000, 8'h11, 8'h01,
                                16'h0000, 16'h0000, 3'b000, 1'b0));
    send_request(directed_frame(8'd11, 8'h88, 16'h0000, 16'h0000, 8'h22, 8'h02,
                                16'h0000, 16'h0000, 3'b000, 1'b1));
    send_request(directed_frame(8'd12, 8'h14, 16'h0000, 16'h0000, 8'h21, 8'h03,
                                16'h0000, 16'h0000, 3'b000, 1'b0));
    send_request(directed_frame(8'd13, 8'h28, 16'h0000, 16'h0000, 8'h12, 8'h04,
                                16'h0000, 16'h0000, 3'b000, 1'b0));
    send_request(directed_frame(8'd14, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00,
                                16'h0000, 16'h0000, 3'b000, 1'b1));
    send_request(directed_frame(8'd255, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                                16'hFFFF, 16'hFFFF, 3'b110, 1'b1));
    send_request(directed_frame(8'd0, 8'h41, 16'h0010, 16'h0000, 8'h0F, 8'h2F,
                                16'h0000, 16'h0000, 3'b000, 1'b1));
    send_request(directed_frame(8'd0, 8'hFF, 16'h0000, 16'h0000, 8'hFF, 8'hFF,
                                16'h0000, 16'h0000, 3'b001, 1'b0));
    drain();
    seq_cursor = 8'd0;
    for (int i = 0; i < PHASES; i++) begin
      zs  = 8'(PHASE_ZS[i]);
      thr = 8'(PHASE_THR[i]);
      if (i == 3) begin
        zs  = 8'($urandom);
        thr = 8'($urandom_range(0, 8));
      end else if (i == 5) begin
        zs = 8'($urandom);
      end
      set_config(zs, thr);
      case (i % 3)
        0: begin
          send_pct = 35;
          recv_pct = 64;
        end
        1: begin
          send_pct = 64;
          recv_pct = 35;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      send_random(PHASE_LEN[i], PHASE_BAD[i]);
      drain();
    end
    repeat (8) @(posedge clk);
    $display("covered %0d requests: %0d new frames, %0d bad checksums, %0d alarmed, %0d stopped",
             tracker.requests, tracker.fresh_frames, tracker.bad_frames,
             tracker.alarm_results, tracker.stop_results);
    $display("speed offset and alarm threshold swept to both extremes over three stall profiles");
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", tracker.errors, tracker.pending());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ptc_pkg.sv
rtl/core/ptc_frame_check.sv
rtl/core/ptc_axis_speed.sv
rtl/core/pan_tilt_command_frame_handler.sv
verif/ptc_frame_check_pkg.sv
verif/tb_top.sv
